### hw/rtl/imu_bias_calibrate_correct_assert.svh
`ifndef IMU_BIAS_CALIBRATE_CORRECT_ASSERT_SVH
`define IMU_BIAS_CALIBRATE_CORRECT_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define IBCC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define IBCC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/ibcc_pkg.sv
`default_nettype none
package ibcc_pkg;

  localparam int AXES       = 3;
  localparam int AXIS_SLOTS = 3;
  localparam int Z_AXIS     = 2;
  localparam int DIV_BITS   = 32;

  localparam logic [1:0] CMD_SAMPLE = 2'd0;
  localparam logic [1:0] CMD_BEGIN  = 2'd1;
  localparam logic [1:0] CMD_ABORT  = 2'd2;

  localparam logic SENSOR_GYRO  = 1'b0;
  localparam logic SENSOR_ACCEL = 1'b1;

  localparam logic REG_SAMPLE_COUNT = 1'b0;
  localparam logic REG_ACCEL_RANGE  = 1'b1;

  localparam logic [15:0] SAMPLE_COUNT_RST = 16'd1000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV_LOAD,
    ST_DIV_STEP,
    ST_DIV_STORE,
    ST_PUSH
  } state_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic div_load;
    logic div_step;
    logic div_store;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic finish;
    logic step_last;
    logic axis_last;
  } dp_stat_t;

  // one g in lsb for each accel full scale
  function automatic logic [15:0] one_g_lsb(input logic [1:0] rng);
    logic [15:0] g;
    case (rng)
      2'd0:    g = 16'd2048;
      2'd1:    g = 16'd4096;
      2'd2:    g = 16'd8192;
      default: g = 16'd16384;
    endcase
    return g;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/ibcc_ctrl.sv
`default_nettype none
module ibcc_ctrl import ibcc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  wire logic     out_stall,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:      if (in_valid) state_nxt = ST_EXEC;
      ST_EXEC:      state_nxt = stat.finish ? ST_DIV_LOAD : ST_PUSH;
      ST_DIV_LOAD:  state_nxt = ST_DIV_STEP;
      ST_DIV_STEP:  if (stat.step_last) state_nxt = ST_DIV_STORE;
      ST_DIV_STORE: state_nxt = stat.axis_last ? ST_PUSH : ST_DIV_LOAD;
      ST_PUSH:      if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      ST_EXEC:      cmd.exec      = 1'b1;
      ST_DIV_LOAD:  cmd.div_load  = 1'b1;
      ST_DIV_STEP:  cmd.div_step  = 1'b1;
      ST_DIV_STORE: cmd.div_store = 1'b1;
      ST_PUSH:      cmd.out_load  = !out_valid_r || !out_stall;
      default:      cmd = '0;
    endcase
  end

  // output beat register: loaded from push, cleared when taken
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

### hw/rtl/ibcc_dp.sv
`default_nettype none
module ibcc_dp import ibcc_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic               cfg_index,
  input  wire logic        [15:0] cfg_data,
  input  wire logic        [1:0]  in_command,
  input  wire logic               in_sensor,
  input  wire logic signed [15:0] in_raw_x,
  input  wire logic signed [15:0] in_raw_y,
  input  wire logic signed [15:0] in_raw_z,
  input  wire dp_cmd_t            cmd,
  output dp_stat_t                stat,
  output logic                    out_sensor,
  output logic signed      [15:0] out_x,
  output logic signed      [15:0] out_y,
  output logic signed      [15:0] out_z,
  output logic                    out_calibrating,
  output logic                    out_calibration_done
);

  // configuration
  logic [15:0] sample_count_r;
  logic [1:0]  accel_range_r;

  // captured item
  logic [1:0]  cmd_r;
  logic        sensor_r;
  logic [15:0] raw_r [AXIS_SLOTS];

  // calibration state
  logic [15:0] gyro_off_r  [AXIS_SLOTS];
  logic [15:0] gyro_off_nxt [AXIS_SLOTS];
  logic [15:0] accel_off_r  [AXIS_SLOTS];
  logic [15:0] accel_off_nxt [AXIS_SLOTS];
  logic [31:0] sum_r   [AXIS_SLOTS];
  logic [31:0] sum_nxt [AXIS_SLOTS];
  logic [15:0] taken_r, taken_nxt;
  logic        active_r, active_nxt;
  logic        target_r, target_nxt;

  // staged result
  logic [15:0] res_r   [AXIS_SLOTS];
  logic [15:0] res_nxt [AXIS_SLOTS];
  logic        done_r, done_nxt;

  // shared serial divider
  logic [1:0]  ax_r, ax_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [31:0] dvd_r, dvd_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic        neg_r, neg_nxt;

  // output beat payload
  logic        o_sensor_r;
  logic [15:0] o_res_r [AXIS_SLOTS];
  logic        o_cal_r;
  logic        o_done_r;

  logic        cal_hit;
  logic [15:0] taken_inc;
  logic        finish;
  logic [31:0] sum_sel;
  logic [16:0] shifted;
  logic [17:0] diff;
  logic        qbit;
  logic [15:0] quot;

  assign cal_hit   = (cmd_r == CMD_SAMPLE) && active_r && (sensor_r == target_r);
  assign taken_inc = taken_r + 16'd1;
  assign finish    = cal_hit && (taken_inc >= sample_count_r);

  assign sum_sel = sum_r[ax_r];
  assign shifted = {rem_r, dvd_r[31]};
  assign diff    = {1'b0, shifted} - {2'b00, taken_r};
  assign qbit    = !diff[17];
  assign quot    = neg_r ? (16'd0 - dvd_r[15:0]) : dvd_r[15:0];

  assign stat.finish    = finish;
  assign stat.step_last = (cnt_r == 5'(DIV_BITS - 1));
  assign stat.axis_last = (ax_r == 2'(AXES - 1));

  always_comb begin
    gyro_off_nxt  = gyro_off_r;
    accel_off_nxt = accel_off_r;
    sum_nxt       = sum_r;
    taken_nxt     = taken_r;
    active_nxt    = active_r;
    target_nxt    = target_r;
    res_nxt       = res_r;
    done_nxt      = done_r;
    ax_nxt        = ax_r;
    cnt_nxt       = cnt_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    neg_nxt       = neg_r;

    if (cmd.exec) begin
      done_nxt = 1'b0;
      ax_nxt   = 2'd0;
      for (int a = 0; a < AXIS_SLOTS; a++) begin
        res_nxt[a] = '0;
      end
      case (cmd_r)
        CMD_SAMPLE: begin
          if (cal_hit) begin
            // target sensor passes raw while its sums build up
            for (int a = 0; a < AXES; a++) begin
              sum_nxt[a] = sum_r[a] + {{16{raw_r[a][15]}}, raw_r[a]};
              res_nxt[a] = raw_r[a];
            end
            taken_nxt = taken_inc;
            if (finish) begin
              active_nxt = 1'b0;
              done_nxt   = 1'b1;
            end
          end else begin
            for (int a = 0; a < AXES; a++) begin
              res_nxt[a] = raw_r[a] -
                           ((sensor_r == SENSOR_ACCEL) ? accel_off_r[a] : gyro_off_r[a]);
            end
          end
        end
        CMD_BEGIN: begin
          if (sample_count_r != 16'd0) begin
            active_nxt = 1'b1;
            target_nxt = sensor_r;
            taken_nxt  = '0;
            for (int a = 0; a < AXIS_SLOTS; a++) begin
              sum_nxt[a] = '0;
            end
          end
        end
        CMD_ABORT: active_nxt = 1'b0;
        default: ;
      endcase
    end

    // divide magnitude, sign restored at store
    if (cmd.div_load) begin
      neg_nxt = sum_sel[31];
      dvd_nxt = sum_sel[31] ? (32'd0 - sum_sel) : sum_sel;
      rem_nxt = '0;
      cnt_nxt = '0;
    end

    if (cmd.div_step) begin
      rem_nxt = qbit ? diff[15:0] : shifted[15:0];
      dvd_nxt = {dvd_r[30:0], qbit};
      cnt_nxt = cnt_r + 5'd1;
    end

    if (cmd.div_store) begin
      if (sensor_r == SENSOR_ACCEL) begin
        if (32'(ax_r) == Z_AXIS) begin
          accel_off_nxt[ax_r] = quot - one_g_lsb(accel_range_r);
        end else begin
          accel_off_nxt[ax_r] = quot;
        end
      end else begin
        gyro_off_nxt[ax_r] = quot;
      end
      ax_nxt = ax_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_count_r <= SAMPLE_COUNT_RST;
      accel_range_r  <= 2'd0;
      taken_r        <= '0;
      active_r       <= 1'b0;
      target_r       <= 1'b0;
      ax_r           <= '0;
      cnt_r          <= '0;
      for (int a = 0; a < AXIS_SLOTS; a++) begin
        gyro_off_r[a]  <= '0;
        accel_off_r[a] <= '0;
        sum_r[a]       <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_SAMPLE_COUNT: sample_count_r <= cfg_data;
          REG_ACCEL_RANGE:  accel_range_r  <= cfg_data[1:0];
          default: ;
        endcase
      end
      taken_r     <= taken_nxt;
      active_r    <= active_nxt;
      target_r    <= target_nxt;
      ax_r        <= ax_nxt;
      cnt_r       <= cnt_nxt;
      gyro_off_r  <= gyro_off_nxt;
      accel_off_r <= accel_off_nxt;
      sum_r       <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r    <= in_command;
      sensor_r <= in_sensor;
      raw_r[0] <= in_raw_x;
      raw_r[1] <= in_raw_y;
      raw_r[2] <= in_raw_z;
    end
    res_r  <= res_nxt;
    done_r <= done_nxt;
    dvd_r  <= dvd_nxt;
    rem_r  <= rem_nxt;
    neg_r  <= neg_nxt;
    if (cmd.out_load) begin
      o_sensor_r <= sensor_r;
      o_res_r    <= res_r;
      o_cal_r    <= active_r;
      o_done_r   <= done_r;
    end
  end

  assign out_sensor           = o_sensor_r;
  assign out_x                = o_res_r[0];
  assign out_y                = o_res_r[1];
  assign out_z                = o_res_r[2];
  assign out_calibrating      = o_cal_r;
  assign out_calibration_done = o_done_r;

endmodule
`default_nettype wire

### hw/rtl/imu_bias_calibrate_correct.sv
// an input beat is captured, run in EXEC, then pushed to the output beat register;
// no new item enters until the last is pushed; a sample that completes a calibration
// runs the shared serial divider per axis (load, 32 one-bit steps, store), 3 axes
// output beat register lets a new item enter while a result waits
// rst_n synchronous active low: offsets, sums, counters cleared, sample_count 1000
`default_nettype none
module imu_bias_calibrate_correct import ibcc_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic               cfg_index,
  input  wire logic        [15:0] cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic        [1:0]  in_command,
  input  wire logic               in_sensor,
  input  wire logic signed [15:0] in_raw_x,
  input  wire logic signed [15:0] in_raw_y,
  input  wire logic signed [15:0] in_raw_z,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_sensor,
  output logic signed      [15:0] out_x,
  output logic signed      [15:0] out_y,
  output logic signed      [15:0] out_z,
  output logic                    out_calibrating,
  output logic                    out_calibration_done
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  ibcc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  ibcc_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_command           (in_command),
    .in_sensor            (in_sensor),
    .in_raw_x             (in_raw_x),
    .in_raw_y             (in_raw_y),
    .in_raw_z             (in_raw_z),
    .cmd                  (cmd),
    .stat                 (stat),
    .out_sensor           (out_sensor),
    .out_x                (out_x),
    .out_y                (out_y),
    .out_z                (out_z),
    .out_calibrating      (out_calibrating),
    .out_calibration_done (out_calibration_done)
  );

endmodule
`default_nettype wire

### hw/rtl/ibcc_chk.sv
`default_nettype none
`include "imu_bias_calibrate_correct_assert.svh"
module ibcc_chk (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic               out_sensor,
  input wire logic signed [15:0] out_x,
  input wire logic signed [15:0] out_y,
  input wire logic signed [15:0] out_z,
  input wire logic               out_calibrating,
  input wire logic               out_calibration_done
);

  // a stalled result beat holds
  `IBCC_ASSERT_NXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(out_x) && $stable(out_y) && $stable(out_z) && $stable(out_sensor),
    "stalled output beat changed")

  // storing new offsets always ends the calibration
  `IBCC_ASSERT_NOW(a_done_ends_cal, out_valid && out_calibration_done,
    !out_calibrating, "calibration_done with calibrating still set")

  // one item at a time: an accepted beat blocks the next cycle
  `IBCC_ASSERT_NXT(a_one_in_flight, in_valid && !in_stall, in_stall,
    "input accepted in back to back cycles")

endmodule

bind imu_bias_calibrate_correct ibcc_chk u_ibcc_chk (.*);
`default_nettype wire
